// ===== hdl/jcp_pkg.sv =====
`default_nettype none

package jcp_pkg;

    // Screen and cell geometry
    localparam int CELL_WIDTH    = 6;
    localparam int CELL_HEIGHT   = 8;
    localparam int SCREEN_WIDTH  = 96;
    localparam int SCREEN_HEIGHT = 64;

    localparam int MAP_COLS = SCREEN_WIDTH / CELL_WIDTH;
    localparam int MAP_ROWS = SCREEN_HEIGHT / CELL_HEIGHT;
    localparam int COL_W    = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int ROW_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAP_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAP_ROWS - 1);

    // Field widths
    localparam int JOY_W  = 8;
    localparam int BTN_W  = 2;
    localparam int KIND_W = 3;
    localparam int X_W    = 7;
    localparam int Y_W    = 6;

    // Commands per tick
    localparam int MAX_CMDS = 4;
    localparam int IDX_W    = 2;
    localparam int CNT_W    = IDX_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [JOY_W-1:0] HIGH_THR_RST = 8'd204;
    localparam logic [JOY_W-1:0] LOW_THR_RST  = 8'd51;
    localparam logic             TRIG_SEL_RST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_THR = 2'd0,
        CFG_LOW_THR  = 2'd1,
        CFG_TRIG_SEL = 2'd2
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        CMD_INIT    = 3'd0,
        CMD_TERM    = 3'd1,
        CMD_PAINT   = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_OUTLINE = 3'd4
    } cmd_kind_t;

    typedef enum logic [1:0] {
        PLAN_NONE,
        PLAN_INIT,
        PLAN_TERM,
        PLAN_ACTIVE
    } plan_kind_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PAINT,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        logic             display_enable;
        logic [JOY_W-1:0] joy_x;
        logic [JOY_W-1:0] joy_y;
        logic [BTN_W-1:0] joy_buttons;
        logic             clear_press;
    } jcp_tick_t;

    typedef struct packed {
        logic [JOY_W-1:0] high_thr;
        logic [JOY_W-1:0] low_thr;
        logic             trig_sel;
    } jcp_cfg_t;

    // What one accepted tick does, settled before the map row is back
    typedef struct packed {
        plan_kind_t       kind;
        cell_op_t         op;
        logic             move;
        logic             stay;
        logic [COL_W-1:0] old_col;
        logic [ROW_W-1:0] old_row;
        logic [COL_W-1:0] new_col;
        logic [ROW_W-1:0] new_row;
    } plan_t;

    typedef struct packed {
        cmd_kind_t      kind;
        logic [X_W-1:0] left_x;
        logic [Y_W-1:0] top_y;
        logic [X_W-1:0] right_x;
        logic [Y_W-1:0] bottom_y;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]           count;
        cmd_t [MAX_CMDS-1:0]        cmds;
    } desc_t;

    function automatic cmd_t make_plain(cmd_kind_t kind);
        cmd_t c;
        c = '0;
        c.kind = kind;
        return c;
    endfunction

    function automatic cmd_t make_rect(cmd_kind_t kind, logic [COL_W-1:0] col,
                                       logic [ROW_W-1:0] row);
        cmd_t        c;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] px_end;
        logic [31:0] py_end;
        px       = 32'(col) * 32'(CELL_WIDTH);
        py       = 32'(row) * 32'(CELL_HEIGHT);
        px_end   = px + 32'(CELL_WIDTH - 1);
        py_end   = py + 32'(CELL_HEIGHT - 1);
        c.kind     = kind;
        c.left_x   = px[X_W-1:0];
        c.top_y    = py[Y_W-1:0];
        c.right_x  = px_end[X_W-1:0];
        c.bottom_y = py_end[Y_W-1:0];
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/jcp_tick_if.sv =====
`default_nettype none

interface jcp_tick_if;
    logic                       valid;
    logic                       ready;
    logic                       display_enable;
    logic [jcp_pkg::JOY_W-1:0]  joy_x;
    logic [jcp_pkg::JOY_W-1:0]  joy_y;
    logic [jcp_pkg::BTN_W-1:0]  joy_buttons;
    logic                       clear_press;

    modport source (
        output valid, display_enable, joy_x, joy_y, joy_buttons, clear_press,
        input  ready
    );

    modport sink (
        input  valid, display_enable, joy_x, joy_y, joy_buttons, clear_press,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/jcp_cmd_if.sv =====
`default_nettype none

interface jcp_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [jcp_pkg::KIND_W-1:0] cmd_kind;
    logic [jcp_pkg::X_W-1:0]    left_x;
    logic [jcp_pkg::Y_W-1:0]    top_y;
    logic [jcp_pkg::X_W-1:0]    right_x;
    logic [jcp_pkg::Y_W-1:0]    bottom_y;
    logic                       last;

    modport source (
        output valid, cmd_kind, left_x, top_y, right_x, bottom_y, last,
        input  ready
    );

    modport sink (
        input  valid, cmd_kind, left_x, top_y, right_x, bottom_y, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/jcp_ram.sv =====
`default_nettype none

module jcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jcp_ctrl.sv =====
`default_nettype none

// Tick front end: cursor, direction and trigger state; builds the plan.
module jcp_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire jcp_pkg::jcp_tick_t        tick_in,
    input  wire jcp_pkg::jcp_cfg_t         cfg,
    input  wire logic                      adv,
    output logic                           plan_valid,
    output jcp_pkg::plan_t                 plan,
    output logic                           rd_en,
    output logic [jcp_pkg::ROW_W-1:0]      rd_row,
    output logic                           clear_all
);

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

    logic                      active_reg, active_next;
    logic [jcp_pkg::COL_W-1:0] col_reg, col_next;
    logic [jcp_pkg::ROW_W-1:0] row_reg, row_next;
    dir_t                      dir_reg, dir_next;
    logic                      trig_reg, trig_next;
    logic                      plan_valid_reg, plan_valid_next;
    jcp_pkg::plan_t            plan_reg, plan_next;

    logic trig;
    dir_t dir;

    always_comb
    begin
        trig = cfg.trig_sel ? tick_in.joy_buttons[0] : tick_in.joy_buttons[1];

        // X before Y
        priority if (tick_in.joy_x > cfg.high_thr)
            dir = DIR_RIGHT;
        else if (tick_in.joy_x < cfg.low_thr)
            dir = DIR_LEFT;
        else if (tick_in.joy_y > cfg.high_thr)
            dir = DIR_UP;
        else if (tick_in.joy_y < cfg.low_thr)
            dir = DIR_DOWN;
        else
            dir = DIR_NONE;
    end

    always_comb
    begin
        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        dir_next    = dir_reg;
        trig_next   = trig_reg;

        plan_next         = '0;
        plan_next.kind    = jcp_pkg::PLAN_NONE;
        plan_next.op      = jcp_pkg::OP_NONE;
        plan_next.old_col = col_reg;
        plan_next.old_row = row_reg;

        if (!tick_in.display_enable)
        begin
            if (active_reg)
            begin
                plan_next.kind = jcp_pkg::PLAN_TERM;
                active_next    = 1'b0;
                col_next       = '0;
                row_next       = '0;
                dir_next       = DIR_NONE;
                trig_next      = 1'b0;
            end
        end
        else if (!active_reg)
        begin
            plan_next.kind = jcp_pkg::PLAN_INIT;
            active_next    = 1'b1;
        end
        else
        begin
            plan_next.kind = jcp_pkg::PLAN_ACTIVE;

            // both trigger edges paint
            if (trig != trig_reg)
            begin
                trig_next    = trig;
                plan_next.op = jcp_pkg::OP_PAINT;
            end
            else if (tick_in.clear_press)
            begin
                plan_next.op = jcp_pkg::OP_CLEAR;
            end

            if (dir != dir_reg)
            begin
                dir_next = dir;
                if (dir != DIR_NONE)
                begin
                    plan_next.move = 1'b1;
                    unique case (dir)
                        DIR_UP:    row_next = (row_reg == '0) ? jcp_pkg::ROW_LAST
                                                              : row_reg - 1'b1;
                        DIR_DOWN:  row_next = (row_reg == jcp_pkg::ROW_LAST) ? '0
                                                              : row_reg + 1'b1;
                        DIR_LEFT:  col_next = (col_reg == '0) ? jcp_pkg::COL_LAST
                                                              : col_reg - 1'b1;
                        DIR_RIGHT: col_next = (col_reg == jcp_pkg::COL_LAST) ? '0
                                                              : col_reg + 1'b1;
                        default:   ;
                    endcase
                end
            end
            else
            begin
                plan_next.stay = 1'b1;
            end
        end

        plan_next.new_col = col_next;
        plan_next.new_row = row_next;

        if (accept)
            plan_valid_next = 1'b1;
        else if (adv)
            plan_valid_next = 1'b0;
        else
            plan_valid_next = plan_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            dir_reg        <= DIR_NONE;
            trig_reg       <= 1'b0;
            plan_valid_reg <= 1'b0;
        end
        else
        begin
            plan_valid_reg <= plan_valid_next;
            if (accept)
            begin
                active_reg <= active_next;
                col_reg    <= col_next;
                row_reg    <= row_next;
                dir_reg    <= dir_next;
                trig_reg   <= trig_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plan_reg <= plan_next;
        end
    end

    assign plan_valid = plan_valid_reg;
    assign plan       = plan_reg;
    assign rd_en      = accept;
    assign rd_row     = row_reg;
    assign clear_all  = accept && !tick_in.display_enable && active_reg;

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < jcp_pkg::MAP_COLS) && (32'(row_reg) < jcp_pkg::MAP_ROWS))
        else $error("cursor outside the cell grid");

    a_init_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid_reg && (plan_reg.kind == jcp_pkg::PLAN_INIT) |-> active_reg)
        else $error("init planned but block not active");

    a_term_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid_reg && (plan_reg.kind == jcp_pkg::PLAN_TERM) |->
            !active_reg && (col_reg == '0) && (row_reg == '0))
        else $error("terminate planned but state not cleared");

endmodule

`default_nettype wire

// ===== hdl/jcp_map.sv =====
`default_nettype none

// Painted-cell map: row RAM, row valid bits, forwarding, command list build.
module jcp_map (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [jcp_pkg::ROW_W-1:0] rd_row,
    input  wire logic                      clear_all,
    input  wire jcp_pkg::plan_t            plan,
    input  wire logic                      wr_go,
    output jcp_pkg::desc_t                 desc
);

    logic [jcp_pkg::MAP_ROWS-1:0] row_valid_reg, row_valid_next;
    logic                         fwd_hit_reg;
    logic [jcp_pkg::MAP_COLS-1:0] fwd_data_reg;
    logic                         vsample_reg;

    logic [jcp_pkg::MAP_COLS-1:0] rd_data;
    logic [jcp_pkg::MAP_COLS-1:0] cur_row;
    logic [jcp_pkg::MAP_COLS-1:0] wr_data;
    logic                         wr_en;
    logic                         cell_bit;

    jcp_ram #(
        .WIDTH (jcp_pkg::MAP_COLS),
        .DEPTH (jcp_pkg::MAP_ROWS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (plan.old_row),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_row),
        .rd_data (rd_data)
    );

    always_comb
    begin
        // a row never written since reset or terminate reads as blank
        cur_row = fwd_hit_reg ? fwd_data_reg : (vsample_reg ? rd_data : '0);

        unique case (plan.op)
            jcp_pkg::OP_PAINT: cell_bit = 1'b1;
            jcp_pkg::OP_CLEAR: cell_bit = 1'b0;
            default:           cell_bit = cur_row[plan.old_col];
        endcase

        wr_data                = cur_row;
        wr_data[plan.old_col]  = cell_bit;
        wr_en                  = wr_go && (plan.kind == jcp_pkg::PLAN_ACTIVE);

        row_valid_next = row_valid_reg;
        if (clear_all)
            row_valid_next = '0;
        else if (wr_en)
            row_valid_next[plan.old_row] = 1'b1;
    end

    always_comb
    begin
        desc = '0;
        unique case (plan.kind)
            jcp_pkg::PLAN_INIT:
            begin
                desc.cmds[0] = jcp_pkg::make_plain(jcp_pkg::CMD_INIT);
                desc.count   = jcp_pkg::CNT_W'(1);
            end
            jcp_pkg::PLAN_TERM:
            begin
                desc.cmds[0] = jcp_pkg::make_plain(jcp_pkg::CMD_TERM);
                desc.count   = jcp_pkg::CNT_W'(1);
            end
            jcp_pkg::PLAN_ACTIVE:
            begin
                if (plan.op != jcp_pkg::OP_NONE)
                begin
                    desc.cmds[desc.count[jcp_pkg::IDX_W-1:0]] = jcp_pkg::make_rect(
                        (plan.op == jcp_pkg::OP_PAINT) ? jcp_pkg::CMD_PAINT
                                                       : jcp_pkg::CMD_CLEAR,
                        plan.old_col, plan.old_row);
                    desc.count = desc.count + 1'b1;
                end
                if (plan.move)
                begin
                    desc.cmds[desc.count[jcp_pkg::IDX_W-1:0]] = jcp_pkg::make_rect(
                        jcp_pkg::CMD_OUTLINE, plan.new_col, plan.new_row);
                    desc.count = desc.count + 1'b1;
                    // restore the cell the cursor left
                    desc.cmds[desc.count[jcp_pkg::IDX_W-1:0]] = jcp_pkg::make_rect(
                        cell_bit ? jcp_pkg::CMD_PAINT : jcp_pkg::CMD_CLEAR,
                        plan.old_col, plan.old_row);
                    desc.count = desc.count + 1'b1;
                end
                else if (plan.stay)
                begin
                    desc.cmds[desc.count[jcp_pkg::IDX_W-1:0]] = jcp_pkg::make_rect(
                        jcp_pkg::CMD_OUTLINE, plan.old_col, plan.old_row);
                    desc.count = desc.count + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
            vsample_reg   <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (rd_en)
            begin
                // read and write of one row in the same cycle: RAM gives old data
                fwd_hit_reg <= wr_en && (plan.old_row == rd_row);
                vsample_reg <= row_valid_reg[rd_row];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    a_clear_wins: assert property (@(posedge clk) disable iff (!rst_n)
        clear_all |=> (row_valid_reg == '0))
        else $error("map rows still marked after terminate");

endmodule

`default_nettype wire

// ===== hdl/jcp_emit.sv =====
`default_nettype none

// Command output stage: walks one tick's command list, one beat per cycle while cmd.ready is high.
module jcp_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           desc_valid,
    input  wire jcp_pkg::desc_t desc,
    output logic                desc_ready,
    jcp_cmd_if.source           cmd
);

    logic                      em_valid_reg, em_valid_next;
    logic [jcp_pkg::IDX_W-1:0] idx_reg, idx_next;
    jcp_pkg::desc_t            desc_reg;

    logic          fire;
    logic          is_last;
    logic          can_load;
    jcp_pkg::cmd_t cur;

    always_comb
    begin
        cur      = desc_reg.cmds[idx_reg];
        fire     = em_valid_reg && cmd.ready;
        is_last  = (jcp_pkg::CNT_W'(idx_reg) + jcp_pkg::CNT_W'(1)) == desc_reg.count;
        can_load = !em_valid_reg || (fire && is_last);

        em_valid_next = em_valid_reg;
        idx_next      = idx_reg;
        if (can_load)
        begin
            em_valid_next = desc_valid;
            idx_next      = '0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            em_valid_reg <= em_valid_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && desc_valid)
        begin
            desc_reg <= desc;
        end
    end

    assign desc_ready   = can_load;
    assign cmd.valid    = em_valid_reg;
    assign cmd.cmd_kind = cur.kind;
    assign cmd.left_x   = cur.left_x;
    assign cmd.top_y    = cur.top_y;
    assign cmd.right_x  = cur.right_x;
    assign cmd.bottom_y = cur.bottom_y;
    assign cmd.last     = is_last;

    a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        em_valid_reg |-> (jcp_pkg::CNT_W'(idx_reg) < desc_reg.count))
        else $error("command index past end of list");

endmodule

`default_nettype wire

// ===== hdl/joystick_cell_painter.sv =====
// Throughput: one command beat per cycle while the receiver holds cmd.ready; a tick
//   that reaches the output has one to three commands, and the single output beat
//   stage loads the next tick's list as the last beat of the current one is taken.
// Reset (rst_n, async, active low): thresholds 204/51, trigger on button bit 0,
//   inactive, cursor at cell 0; all map rows read blank until first written.
`default_nettype none

module joystick_cell_painter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    jcp_tick_if.sink                            tick,
    jcp_cmd_if.source                           cmd,
    input  wire logic                           cfg_we,
    input  wire logic [jcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [jcp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [jcp_pkg::JOY_W-1:0] high_thr_reg;
    logic [jcp_pkg::JOY_W-1:0] low_thr_reg;
    logic                      trig_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= jcp_pkg::HIGH_THR_RST;
            low_thr_reg  <= jcp_pkg::LOW_THR_RST;
            trig_sel_reg <= jcp_pkg::TRIG_SEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jcp_pkg::CFG_HIGH_THR: high_thr_reg <= cfg_data[jcp_pkg::JOY_W-1:0];
                jcp_pkg::CFG_LOW_THR:  low_thr_reg  <= cfg_data[jcp_pkg::JOY_W-1:0];
                jcp_pkg::CFG_TRIG_SEL: trig_sel_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    jcp_pkg::jcp_cfg_t  cfg;
    jcp_pkg::jcp_tick_t tick_in;

    always_comb
    begin
        cfg.high_thr = high_thr_reg;
        cfg.low_thr  = low_thr_reg;
        cfg.trig_sel = trig_sel_reg;

        tick_in.display_enable = tick.display_enable;
        tick_in.joy_x          = tick.joy_x;
        tick_in.joy_y          = tick.joy_y;
        tick_in.joy_buttons    = tick.joy_buttons;
        tick_in.clear_press    = tick.clear_press;
    end

    // Pipeline:
    //   stage 0  tick beat accepted; control state updated, plan registered,
    //            the cursor's map row read from RAM.
    //   stage 1  row back from RAM (or forwarded); cell bit settled, row written
    //            back, command list built and handed to the output stage.
    //   output   one command beat per cycle while cmd.ready is high, last flagged on the final one.
    // A tick that yields no command leaves stage 1 without touching the output.
    logic                      accept;
    logic                      plan_valid;
    jcp_pkg::plan_t            plan;
    logic                      rd_en;
    logic [jcp_pkg::ROW_W-1:0] rd_row;
    logic                      clear_all;
    jcp_pkg::desc_t            desc;
    logic                      desc_ready;
    logic                      desc_valid;
    logic                      adv;

    assign desc_valid = plan_valid && (desc.count != '0);
    assign adv        = plan_valid && ((desc.count == '0) || desc_ready);
    assign tick.ready = !plan_valid || adv;
    assign accept     = tick.valid && tick.ready;

    jcp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .tick_in    (tick_in),
        .cfg        (cfg),
        .adv        (adv),
        .plan_valid (plan_valid),
        .plan       (plan),
        .rd_en      (rd_en),
        .rd_row     (rd_row),
        .clear_all  (clear_all)
    );

    // Row write-back happens as the plan leaves stage 1
    jcp_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_row    (rd_row),
        .clear_all (clear_all),
        .plan      (plan),
        .wr_go     (adv),
        .desc      (desc)
    );

    jcp_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_ready (desc_ready),
        .cmd        (cmd)
    );

    a_stage1_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid && adv && !accept |=> !plan_valid)
        else $error("stage 1 plan not retired");

endmodule

`default_nettype wire

// ===== verif/joystick_cell_painter_tb.sv =====
`default_nettype none

module joystick_cell_painter_tb;

    import jcp_pkg::*;

    // Limit on consecutive cycles with no beat on either channel
    localparam int QUIET_LIMIT = 2000;
    // Settle time after the last command beat before a register write
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT = 12;

    // Last whole-cell corner on each axis, used for the wrap
    localparam int LAST_X = (MAP_COLS - 1) * CELL_WIDTH;
    localparam int LAST_Y = (MAP_ROWS - 1) * CELL_HEIGHT;

    typedef enum logic [2:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } stick_dir_t;

    // One command beat as it appears on the output channel
    typedef struct packed {
        cmd_kind_t      kind;
        logic [X_W-1:0] left_x;
        logic [Y_W-1:0] top_y;
        logic [X_W-1:0] right_x;
        logic [Y_W-1:0] bottom_y;
        logic           last;
    } cmd_beat_t;

    // One row of the directed table; typed rows carry their single command
    typedef struct {
        jcp_tick_t t;
        bit        typed;
        cmd_beat_t want;
    } tick_row_t;

    localparam cmd_beat_t BEAT_INIT = '{CMD_INIT, 7'd0, 6'd0, 7'd0, 6'd0, 1'b1};
    localparam cmd_beat_t BEAT_TERM = '{CMD_TERM, 7'd0, 6'd0, 7'd0, 6'd0, 1'b1};
    // Cursor outline at the home cell
    localparam cmd_beat_t BEAT_HOME = '{CMD_OUTLINE, 7'd0, 6'd0, 7'd5, 6'd7, 1'b1};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    jcp_tick_if tick_bus ();
    jcp_cmd_if  cmd_bus ();

    joystick_cell_painter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_bus),
        .cmd       (cmd_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Painter shadow state: settings, cursor in pixels, previous stick and trigger
    logic [7:0] cfg_hi;
    logic [7:0] cfg_lo;
    logic       cfg_sel;
    bit         pn_active;
    int         pn_x;
    int         pn_y;
    stick_dir_t pn_dir;
    logic       pn_trig;
    bit         painted [MAP_ROWS][MAP_COLS];

    cmd_beat_t  tick_cmds [$];   // commands of the tick just accepted
    cmd_beat_t  due_cmds [$];    // commands still owed by the block, oldest first
    cmd_beat_t  want_beat;

    tick_row_t  plan_rows [$];
    int         errors = 0;
    int         beats_seen = 0;
    int         quiet_cycles = 0;
    int         rand_count = 0;
    int         hold_left = 0;
    bit         held = 0;

    always #6 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic jcp_tick_t mk_tick(input logic en, input logic [7:0] jx,
                                          input logic [7:0] jy, input logic [1:0] btn,
                                          input logic clr);
        jcp_tick_t t;
        t.display_enable = en;
        t.joy_x          = jx;
        t.joy_y          = jy;
        t.joy_buttons    = btn;
        t.clear_press    = clr;
        return t;
    endfunction

    function automatic cmd_beat_t cell_rect(input cmd_kind_t k, input int x, input int y);
        cmd_beat_t b;
        b.kind     = k;
        b.left_x   = X_W'(x);
        b.top_y    = Y_W'(y);
        b.right_x  = X_W'(x + CELL_WIDTH - 1);
        b.bottom_y = Y_W'(y + CELL_HEIGHT - 1);
        b.last     = 1'b0;
        return b;
    endfunction

    function automatic cmd_beat_t bare_cmd(input cmd_kind_t k);
        cmd_beat_t b;
        b      = '0;
        b.kind = k;
        return b;
    endfunction

    task automatic clear_painter();
        pn_active = 0;
        pn_x      = 0;
        pn_y      = 0;
        pn_dir    = DIR_NONE;
        pn_trig   = 1'b0;
        foreach (painted[r, c])
            painted[r][c] = 0;
    endtask

    // Works out the commands one tick causes and updates the shadow state
    task automatic paint_cmds_for_tick(input jcp_tick_t t);
        logic       trig;
        stick_dir_t dir;
        int         ox;
        int         oy;
        tick_cmds.delete();
        if (!t.display_enable)
        begin
            if (pn_active)
            begin
                clear_painter();
                tick_cmds.push_back(bare_cmd(CMD_TERM));
            end
        end
        else if (!pn_active)
        begin
            pn_active = 1;
            tick_cmds.push_back(bare_cmd(CMD_INIT));
        end
        else
        begin
            // Trigger edge of either polarity paints; clear only without an edge
            trig = cfg_sel ? t.joy_buttons[0] : t.joy_buttons[1];
            if (trig != pn_trig)
            begin
                pn_trig = trig;
                tick_cmds.push_back(cell_rect(CMD_PAINT, pn_x, pn_y));
                painted[pn_y / CELL_HEIGHT][pn_x / CELL_WIDTH] = 1;
            end
            else if (t.clear_press)
            begin
                tick_cmds.push_back(cell_rect(CMD_CLEAR, pn_x, pn_y));
                painted[pn_y / CELL_HEIGHT][pn_x / CELL_WIDTH] = 0;
            end

            // X wins over Y
            if (t.joy_x > cfg_hi)
                dir = DIR_RIGHT;
            else if (t.joy_x < cfg_lo)
                dir = DIR_LEFT;
            else if (t.joy_y > cfg_hi)
                dir = DIR_UP;
            else if (t.joy_y < cfg_lo)
                dir = DIR_DOWN;
            else
                dir = DIR_NONE;

            if (dir != pn_dir)
            begin
                pn_dir = dir;
                // A change back to neutral draws nothing
                if (dir != DIR_NONE)
                begin
                    ox = pn_x;
                    oy = pn_y;
                    case (dir)
                        DIR_UP:    pn_y = (pn_y < CELL_HEIGHT) ? LAST_Y : pn_y - CELL_HEIGHT;
                        DIR_DOWN:  pn_y = (pn_y + CELL_HEIGHT > LAST_Y) ? 0 : pn_y + CELL_HEIGHT;
                        DIR_LEFT:  pn_x = (pn_x < CELL_WIDTH) ? LAST_X : pn_x - CELL_WIDTH;
                        default:   pn_x = (pn_x + CELL_WIDTH > LAST_X) ? 0 : pn_x + CELL_WIDTH;
                    endcase
                    tick_cmds.push_back(cell_rect(CMD_OUTLINE, pn_x, pn_y));
                    // Restore the cell the cursor left
                    if (painted[oy / CELL_HEIGHT][ox / CELL_WIDTH])
                        tick_cmds.push_back(cell_rect(CMD_PAINT, ox, oy));
                    else
                        tick_cmds.push_back(cell_rect(CMD_CLEAR, ox, oy));
                end
            end
            else
                tick_cmds.push_back(cell_rect(CMD_OUTLINE, pn_x, pn_y));
        end
        if (tick_cmds.size() > 0)
            tick_cmds[tick_cmds.size() - 1].last = 1'b1;
    endtask

    // Offers one tick beat, optionally after random gaps, and logs what it owes
    task automatic offer_tick(input tick_row_t row, input bit may_idle);
        @(negedge clk);
        while (may_idle && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            tick_bus.valid <= 1'b0;
            @(negedge clk);
        end
        tick_bus.valid          <= 1'b1;
        tick_bus.display_enable <= row.t.display_enable;
        tick_bus.joy_x          <= row.t.joy_x;
        tick_bus.joy_y          <= row.t.joy_y;
        tick_bus.joy_buttons    <= row.t.joy_buttons;
        tick_bus.clear_press    <= row.t.clear_press;
        @(posedge clk);
        while (!tick_bus.ready)
            @(posedge clk);
        paint_cmds_for_tick(row.t);
        if (row.typed)
            due_cmds.push_back(row.want);
        else
            foreach (tick_cmds[i])
                due_cmds.push_back(tick_cmds[i]);
    endtask

    // Sender goes quiet until every owed command is out, then lets the block drain
    task automatic settle();
        @(negedge clk);
        tick_bus.valid <= 1'b0;
        while (due_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Three back-to-back register beats, enable dropped after the last one
    task automatic write_settings(input logic [7:0] hi, input logic [7:0] lo, input logic sel);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HIGH_THR;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_index <= CFG_LOW_THR;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= CFG_TRIG_SEL;
        cfg_data  <= {7'd0, sel};
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_hi  = hi;
        cfg_lo  = lo;
        cfg_sel = sel;
    endtask

    // Axis values: mostly between the thresholds, else at and around them or the rails
    function automatic logic [7:0] pick_axis();
        case ($urandom_range(0, 6))
            0, 1, 2: return 8'((int'(cfg_hi) + int'(cfg_lo)) / 2);
            3:       return 8'($urandom_range(0, 255));
            4:       return 8'(cfg_hi + $urandom_range(0, 1));
            5:       return 8'(cfg_lo - $urandom_range(0, 1));
            default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
    endfunction

    function automatic tick_row_t rand_row();
        tick_row_t r;
        // Enable drops now and then so init/terminate recur mid-stream
        r.t.display_enable = ($urandom_range(0, 99) >= 4);
        r.t.joy_x          = pick_axis();
        r.t.joy_y          = pick_axis();
        r.t.joy_buttons    = 2'($urandom_range(0, 3));
        r.t.clear_press    = ($urandom_range(0, 3) == 0);
        r.typed            = 0;
        r.want             = '0;
        return r;
    endfunction

    // Output checker: every command beat is matched against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && cmd_bus.valid && cmd_bus.ready)
        begin
            beats_seen++;
            if (due_cmds.size() == 0)
                report_mismatch($sformatf("unexpected command beat, kind %0d", cmd_bus.cmd_kind));
            else
            begin
                want_beat = due_cmds.pop_front();
                check_field("cmd_kind", cmd_bus.cmd_kind, want_beat.kind);
                check_field("left_x", cmd_bus.left_x, want_beat.left_x);
                check_field("top_y", cmd_bus.top_y, want_beat.top_y);
                check_field("right_x", cmd_bus.right_x, want_beat.right_x);
                check_field("bottom_y", cmd_bus.bottom_y, want_beat.bottom_y);
                check_field("last", cmd_bus.last, want_beat.last);
            end
        end
    end

    // Receiver: random backpressure, one long hold-off, and a window with none
    initial
    begin
        cmd_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && beats_seen >= 60)
            begin
                held      = 1;
                hold_left = 250;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cmd_bus.ready <= 1'b0;
            end
            else if (beats_seen >= 150 && beats_seen < 250)
                cmd_bus.ready <= 1'b1;
            else
                cmd_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog on consecutive cycles without any accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (tick_bus.valid && tick_bus.ready) || (cmd_bus.valid && cmd_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[joystick_cell_painter] ERROR");
            $finish;
        end
    end

    initial
    begin
        int         ph;
        int         n;
        logic [7:0] hi;
        logic [7:0] lo;
        logic       sel;

        clk                     = 1'b0;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        tick_bus.valid          = 1'b0;
        tick_bus.display_enable = 1'b0;
        tick_bus.joy_x          = '0;
        tick_bus.joy_y          = '0;
        tick_bus.joy_buttons    = '0;
        tick_bus.clear_press    = 1'b0;

        cfg_hi  = HIGH_THR_RST;
        cfg_lo  = LOW_THR_RST;
        cfg_sel = TRIG_SEL_RST;
        clear_painter();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, reset settings: thresholds 204/51, trigger on bit 0
        plan_rows.push_back('{mk_tick(1, 128, 128, 0, 0), 1, BEAT_INIT});  // enable rises
        plan_rows.push_back('{mk_tick(1, 128, 128, 0, 0), 1, BEAT_HOME});  // idle stick
        plan_rows.push_back('{mk_tick(1, 128, 128, 1, 0), 0, '0});  // press paints
        plan_rows.push_back('{mk_tick(1, 255, 128, 1, 0), 0, '0});  // move right
        plan_rows.push_back('{mk_tick(1, 255, 128, 1, 0), 0, '0});  // held direction
        plan_rows.push_back('{mk_tick(1, 128, 128, 0, 1), 0, '0});  // release beats clear
        plan_rows.push_back('{mk_tick(1, 0, 128, 0, 1), 0, '0});    // clear, then left
        plan_rows.push_back('{mk_tick(1, 128, 128, 0, 0), 0, '0});  // back to neutral: nothing
        plan_rows.push_back('{mk_tick(1, 0, 255, 0, 0), 0, '0});    // left wraps, x over y
        plan_rows.push_back('{mk_tick(1, 204, 51, 0, 0), 0, '0});   // on thresholds: neutral
        plan_rows.push_back('{mk_tick(1, 205, 128, 0, 0), 0, '0});  // right wraps to 0
        plan_rows.push_back('{mk_tick(1, 51, 255, 0, 0), 0, '0});   // up wraps to bottom
        plan_rows.push_back('{mk_tick(1, 128, 50, 0, 0), 0, '0});   // down wraps to top
        plan_rows.push_back('{mk_tick(1, 128, 50, 2, 0), 0, '0});   // bit 1 not the trigger
        plan_rows.push_back('{mk_tick(1, 50, 50, 3, 1), 0, '0});    // press and left
        plan_rows.push_back('{mk_tick(1, 255, 0, 3, 0), 0, '0});    // x over y: right
        plan_rows.push_back('{mk_tick(1, 255, 0, 1, 1), 0, '0});    // clear and outline
        plan_rows.push_back('{mk_tick(0, 255, 255, 3, 1), 1, BEAT_TERM});  // enable falls
        plan_rows.push_back('{mk_tick(0, 0, 0, 0, 0), 0, '0});      // inactive: nothing
        plan_rows.push_back('{mk_tick(1, 0, 0, 3, 1), 1, BEAT_INIT});
        plan_rows.push_back('{mk_tick(1, 0, 0, 3, 1), 0, '0});      // wrap left from home
        plan_rows.push_back('{mk_tick(1, 128, 255, 0, 0), 0, '0});
        plan_rows.push_back('{mk_tick(1, 255, 255, 2, 1), 0, '0});
        foreach (plan_rows[i])
            offer_tick(plan_rows[i], 1);

        // Random phases, each under its own settings; block drained between them
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       begin hi = 8'd255; lo = 8'd0;   sel = 1'b1; end  // stick never counts
                1:       begin hi = 8'd0;   lo = 8'd255; sel = 1'b0; end  // always deflected
                2:       begin hi = 8'd204; lo = 8'd51;  sel = 1'b0; end
                3:       begin hi = 8'd128; lo = 8'd127; sel = 1'b1; end
                default:
                begin
                    hi  = 8'($urandom_range(128, 255));
                    lo  = 8'($urandom_range(0, 127));
                    sel = 1'($urandom_range(0, 1));
                end
            endcase
            settle();
            write_settings(hi, lo, sel);
            for (n = 0; n < 32; n++)
            begin
                // A stretch of back-to-back ticks with no gaps
                offer_tick(rand_row(), !(rand_count >= 100 && rand_count < 140));
                rand_count++;
            end
        end

        @(negedge clk);
        tick_bus.valid <= 1'b0;
        while (due_cmds.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (errors == 0)
            $display("[joystick_cell_painter] OK");
        else
            $display("[joystick_cell_painter] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/jcp_pkg.sv
hdl/jcp_tick_if.sv
hdl/jcp_cmd_if.sv
hdl/jcp_ram.sv
hdl/jcp_ctrl.sv
hdl/jcp_map.sv
hdl/jcp_emit.sv
hdl/joystick_cell_painter.sv
verif/joystick_cell_painter_tb.sv
